// ===== rtl/bqr_pkg.sv =====
// bisection quartic root: shared types and constants
// no dependencies
`default_nettype none
package bqr_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int unsigned TOL_ONE_SHIFT = 16;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_BAD_BRACKET = 2'd1,
        ST_CAP = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_COEF_X4 = 3'd0,
        REG_COEF_X3 = 3'd1,
        REG_COEF_X2 = 3'd2,
        REG_COEF_X1 = 3'd3,
        REG_COEF_X0 = 3'd4,
        REG_TOL = 3'd5,
        REG_MAXIT = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVL,
        S_EVR,
        S_CHECK,
        S_MID,
        S_EVM,
        S_TEST,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic [31:0] x;
    } t_peval_req;
endpackage
`default_nettype wire

// ===== rtl/bqr_peval.sv =====
// bisection quartic root: horner evaluator of the quartic on one shared multiplier
// depends on bqr_pkg; two 32x32 partial products and a combine per horner step
`default_nettype none
module bqr_peval #(
    parameter int FRAC_BITS = bqr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bqr_pkg::t_peval_req   i_req,
    input  wire logic [31:0]           i_c4,
    input  wire logic [31:0]           i_c3,
    input  wire logic [31:0]           i_c2,
    input  wire logic [31:0]           i_c1,
    input  wire logic [31:0]           i_c0,
    output logic                       o_done,
    output logic signed [63:0]         o_val
);
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HI_LIM = SAT_MAX >> (32 - FRAC_BITS);

    // phase 0: low product, phase 1: high product, phase 2: combine and add
    logic        r_busy, n_busy;
    logic [1:0]  r_ph, n_ph;
    logic [1:0]  r_k, n_k;
    logic [63:0] r_ua, n_ua;
    logic [31:0] r_ux, n_ux;
    logic        r_neg, n_neg;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_hi, n_hi;
    logic signed [63:0] r_acc, n_acc;
    logic        r_done, n_done;
    logic        r_ux_neg_q;

    logic [31:0] w_ma;
    logic [63:0] w_prod;
    logic [63:0] w_r;
    logic signed [63:0] w_m;
    logic signed [63:0] w_c;
    logic signed [64:0] w_sum;
    logic signed [63:0] w_acc_new;
    logic        w_x_neg;

    assign w_ma = (r_ph == 2'd0) ? r_ua[31:0] : r_ua[63:32];
    assign w_prod = {32'd0, w_ma} * {32'd0, r_ux};

    always_comb begin
        case (r_k)
            2'd0: w_c = {{32{i_c3[31]}}, i_c3};
            2'd1: w_c = {{32{i_c2[31]}}, i_c2};
            2'd2: w_c = {{32{i_c1[31]}}, i_c1};
            default: w_c = {{32{i_c0[31]}}, i_c0};
        endcase
    end

    always_comb begin
        if (r_hi > HI_LIM) begin
            w_r = SAT_MAX;
        end else begin
            w_r = (r_hi << (32 - FRAC_BITS)) + (r_lo >> FRAC_BITS);
            if (w_r > SAT_MAX) w_r = SAT_MAX;
        end
        w_m = r_neg ? -$signed(w_r) : $signed(w_r);
        w_sum = {w_m[63], w_m} + {w_c[63], w_c};
        if (w_sum[64] != w_sum[63])
            w_acc_new = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            w_acc_new = w_sum[63:0];
    end

    assign w_x_neg = i_req.x[31];

    always_comb begin
        n_busy = r_busy;
        n_ph = r_ph;
        n_k = r_k;
        n_ua = r_ua;
        n_ux = r_ux;
        n_neg = r_neg;
        n_lo = r_lo;
        n_hi = r_hi;
        n_acc = r_acc;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_ph = 2'd0;
            n_k = 2'd0;
            n_acc = {{32{i_c4[31]}}, i_c4};
            n_ux = w_x_neg ? (32'd0 - i_req.x) : i_req.x;
            n_ua = i_c4[31] ? (64'd0 - {{32{i_c4[31]}}, i_c4}) : {32'd0, i_c4};
            n_neg = i_c4[31] ^ w_x_neg;
        end else if (r_busy) begin
            case (r_ph)
                2'd0: begin
                    n_lo = w_prod;
                    n_ph = 2'd1;
                end
                2'd1: begin
                    n_hi = w_prod;
                    n_ph = 2'd2;
                end
                default: begin
                    n_acc = w_acc_new;
                    n_ph = 2'd0;
                    n_ua = w_acc_new[63] ? (64'd0 - w_acc_new) : w_acc_new;
                    n_neg = w_acc_new[63] ^ r_ux_neg_q;
                    n_k = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) r_ux_neg_q <= w_x_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph <= 2'd0;
            r_k <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ph <= n_ph;
            r_k <= n_k;
        end
        r_ua <= n_ua;
        r_ux <= n_ux;
        r_neg <= n_neg;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_val = r_acc;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while busy");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_ph != 2'd3) else $error("bad phase");
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without work");
endmodule
`default_nettype wire

// ===== rtl/bisection_quartic_root.sv =====
// bisection quartic root finder, top level: sequencer, config registers, output stage
// each evaluation runs on the shared multiplier, for both bracket ends and for every midpoint
// one bracket in flight at a time; input stall stays high until the result is staged
// synchronous active-low reset restores the default coefficients and clears control
`default_nettype none
module bisection_quartic_root #(
    parameter int FRAC_BITS = bqr_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_left_bracket,
    input  wire logic [31:0] i_right_bracket,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_root,
    output logic [1:0]       o_status,
    output logic [7:0]       o_steps_taken,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    localparam logic [31:0] C4_RST = 32'(64'sd19 <<< FRAC_BITS);
    localparam logic [31:0] C3_RST = 32'(-64'sd110 * (64'sd1 <<< FRAC_BITS));
    localparam logic [31:0] C2_RST = 32'(-64'sd3300 * (64'sd1 <<< FRAC_BITS));
    localparam logic [31:0] C0_RST = 32'(64'sd12000 <<< FRAC_BITS);

    logic [31:0] r_c4, r_c3, r_c2, r_c1, r_c0;
    logic [15:0] r_tol;
    logic [7:0]  r_maxit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4 <= C4_RST;
            r_c3 <= C3_RST;
            r_c2 <= C2_RST;
            r_c1 <= 32'd0;
            r_c0 <= C0_RST;
            r_tol <= 16'd66;
            r_maxit <= 8'd64;
        end else if (i_cfg_we) begin
            case (bqr_pkg::t_reg_idx'(i_cfg_idx))
                bqr_pkg::REG_COEF_X4: r_c4 <= i_cfg_data;
                bqr_pkg::REG_COEF_X3: r_c3 <= i_cfg_data;
                bqr_pkg::REG_COEF_X2: r_c2 <= i_cfg_data;
                bqr_pkg::REG_COEF_X1: r_c1 <= i_cfg_data;
                bqr_pkg::REG_COEF_X0: r_c0 <= i_cfg_data;
                bqr_pkg::REG_TOL:     r_tol <= i_cfg_data[15:0];
                bqr_pkg::REG_MAXIT:   r_maxit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bqr_pkg::t_state r_st, n_st;
    logic signed [31:0] r_l, n_l, r_r, n_r, r_m, n_m;
    logic signed [63:0] r_fl, n_fl, r_fm, n_fm;
    logic [7:0]  r_steps, n_steps;
    logic [7:0]  r_cap, n_cap;
    logic        r_going, n_going;
    logic        r_ov, n_ov;
    logic [31:0] r_oroot, n_oroot;
    logic [1:0]  r_ostat, n_ostat;
    logic [7:0]  r_osteps, n_osteps;
    logic [1:0]  r_pstat, n_pstat;
    logic signed [63:0] r_lhs, n_lhs, r_rhs, n_rhs;

    bqr_pkg::t_peval_req w_req;
    logic w_done;
    logic signed [63:0] w_val;

    bqr_peval #(.FRAC_BITS(FRAC_BITS)) u_peval (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .i_c4(r_c4), .i_c3(r_c3), .i_c2(r_c2), .i_c1(r_c1), .i_c0(r_c0),
        .o_done(w_done), .o_val(w_val)
    );

    logic signed [32:0] w_s;
    logic signed [32:0] w_w;
    logic        w_in_acc;
    logic [1:0]  w_sl, w_sm;

    assign w_in_acc = i_valid && !o_stall;
    assign w_s = {r_l[31], r_l} + {r_r[31], r_r};
    assign w_w = {r_r[31], r_r} - {r_l[31], r_l};
    assign w_sl = {r_fl[63], r_fl != 64'sd0};
    assign w_sm = {r_fm[63], r_fm != 64'sd0};

    always_comb begin
        n_st = r_st;
        n_l = r_l;
        n_r = r_r;
        n_m = r_m;
        n_fl = r_fl;
        n_fm = r_fm;
        n_steps = r_steps;
        n_cap = r_cap;
        n_going = r_going;
        n_ov = r_ov;
        n_oroot = r_oroot;
        n_ostat = r_ostat;
        n_osteps = r_osteps;
        n_pstat = r_pstat;
        n_lhs = r_lhs;
        n_rhs = r_rhs;
        w_req.start = 1'b0;
        w_req.x = r_l;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_st)
            bqr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_l = i_left_bracket;
                    n_r = i_right_bracket;
                    n_cap = (r_maxit == 8'd0) ? 8'd1 : r_maxit;
                    n_steps = 8'd0;
                    n_m = 32'sd0;
                    n_st = bqr_pkg::S_EVL;
                    w_req.start = 1'b1;
                    w_req.x = i_left_bracket;
                end
            end
            bqr_pkg::S_EVL: begin
                if (w_done) begin
                    n_fl = w_val;
                    w_req.start = 1'b1;
                    w_req.x = r_r;
                    n_st = bqr_pkg::S_EVR;
                end
            end
            bqr_pkg::S_EVR: begin
                if (w_done) begin
                    n_fm = w_val;
                    n_st = bqr_pkg::S_CHECK;
                end
            end
            bqr_pkg::S_CHECK: begin
                if (w_sl[0] && w_sm[0] && (w_sl[1] == w_sm[1])) begin
                    n_m = 32'sd0;
                    n_steps = 8'd0;
                    n_pstat = bqr_pkg::ST_BAD_BRACKET;
                    n_st = bqr_pkg::S_OUT;
                end else begin
                    n_st = bqr_pkg::S_MID;
                end
            end
            bqr_pkg::S_MID: begin
                n_m = w_s[32:1];
                n_lhs = 64'(w_w) <<< bqr_pkg::TOL_ONE_SHIFT;
                w_req.start = 1'b1;
                w_req.x = w_s[32:1];
                n_st = bqr_pkg::S_EVM;
            end
            bqr_pkg::S_EVM: begin
                if (w_done) begin
                    n_fm = w_val;
                    n_rhs = $signed({32'd0, 16'd0, r_tol}) * 64'(r_m);
                    n_st = bqr_pkg::S_TEST;
                end
            end
            bqr_pkg::S_TEST: begin
                if (r_m > 32'sd0) n_going = r_lhs > r_rhs;
                else if (r_m < 32'sd0) n_going = r_lhs < r_rhs;
                else n_going = 1'b1;
                n_st = bqr_pkg::S_UPDATE;
            end
            bqr_pkg::S_UPDATE: begin
                if (w_sl[0] && w_sm[0] && (w_sl[1] != w_sm[1])) begin
                    n_r = r_m;
                end else begin
                    n_l = r_m;
                    n_fl = r_fm;
                end
                n_steps = r_steps + 8'd1;
                if (r_going && (r_steps + 8'd1) < r_cap) begin
                    n_st = bqr_pkg::S_MID;
                end else begin
                    n_pstat = r_going ? bqr_pkg::ST_CAP : bqr_pkg::ST_CONVERGED;
                    n_st = bqr_pkg::S_OUT;
                end
            end
            bqr_pkg::S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_oroot = r_m;
                    n_ostat = r_pstat;
                    n_osteps = r_steps;
                    n_st = bqr_pkg::S_IDLE;
                end
            end
            default: n_st = bqr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bqr_pkg::S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
        r_l <= n_l;
        r_r <= n_r;
        r_m <= n_m;
        r_fl <= n_fl;
        r_fm <= n_fm;
        r_steps <= n_steps;
        r_cap <= n_cap;
        r_going <= n_going;
        r_lhs <= n_lhs;
        r_rhs <= n_rhs;
        r_pstat <= n_pstat;
        r_oroot <= n_oroot;
        r_ostat <= n_ostat;
        r_osteps <= n_osteps;
    end

    assign o_stall = (r_st != bqr_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_root = r_oroot;
    assign o_status = r_ostat;
    assign o_steps_taken = r_osteps;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status code");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bqr_pkg::ST_BAD_BRACKET) |-> o_steps_taken == 8'd0)
        else $error("bad bracket with steps");
    a_steps_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == bqr_pkg::S_UPDATE) |-> r_steps < r_cap) else $error("steps past cap");
endmodule
`default_nettype wire

// ===== dv/bisection_quartic_root_test.sv =====
// self-checking testbench for bisection_quartic_root: queue-fed driver, clocked monitor,
// and a bit-exact predictor of the bisection search; depends on rtl/bqr_pkg.sv and the rtl top
`default_nettype none
module bisection_quartic_root_test;
    localparam int FB = 16;
    localparam int LIMIT = 20000000;
    localparam int DRAIN = 5000;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
    } t_bracket;

    typedef struct {
        logic [31:0] root;
        bqr_pkg::t_status status;
        logic [7:0] steps;
    } t_answer;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [31:0] i_left_bracket = 0;
    logic [31:0] i_right_bracket = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [31:0] o_root;
    logic [1:0] o_status;
    logic [7:0] o_steps_taken;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;

    bisection_quartic_root i_dut (.*);

    always #2 i_clk = ~i_clk;

    logic [31:0] m_c4, m_c3, m_c2, m_c1, m_c0;
    logic [15:0] m_tol;
    logic [7:0] m_maxit;

    t_bracket brackets_pending[$];
    t_answer answers_due[$];
    int fails = 0;
    int cycles = 0;
    bit hold = 0;
    bit beat_taken = 0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint mul_shift(longint a, longint x);
        logic signed [127:0] sa, sx;
        logic [127:0] p;
        bit neg;
        sa = a;
        sx = x;
        neg = (a < 0) != (x < 0);
        if (sa < 0) sa = -sa;
        if (sx < 0) sx = -sx;
        p = (sa * sx) >> FB;
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint add_sat(longint a, logic [31:0] c);
        logic signed [127:0] s;
        s = 128'(a) + 128'(int'(c));
        if (s > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(s[63:0]);
    endfunction

    function automatic longint eval_quartic(longint x);
        longint acc;
        acc = int'(m_c4);
        acc = add_sat(mul_shift(acc, x), m_c3);
        acc = add_sat(mul_shift(acc, x), m_c2);
        acc = add_sat(mul_shift(acc, x), m_c1);
        acc = add_sat(mul_shift(acc, x), m_c0);
        return acc;
    endfunction

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic t_answer solve_bracket(t_bracket b);
        t_answer a;
        longint lo, hi, f_lo, f_hi, f_mid, mid, s, w, tol;
        int cap, steps;
        bit going;
        lo = int'(b.left);
        hi = int'(b.right);
        tol = m_tol;
        cap = (m_maxit == 0) ? 1 : m_maxit;
        f_lo = eval_quartic(lo);
        f_hi = eval_quartic(hi);
        mid = 0;
        steps = 0;
        going = 1;
        if (sgn(f_lo) * sgn(f_hi) > 0) begin
            a.root = 0;
            a.status = bqr_pkg::ST_BAD_BRACKET;
            a.steps = 0;
            return a;
        end
        while (going && steps < cap) begin
            s = lo + hi;
            w = hi - lo;
            mid = s >>> 1;
            f_mid = eval_quartic(mid);
            if (mid > 0) going = w * 65536 > tol * mid;
            else if (mid < 0) going = w * 65536 < tol * mid;
            else going = 1;
            if (sgn(f_lo) * sgn(f_mid) < 0) begin
                hi = mid;
            end else begin
                lo = mid;
                f_lo = f_mid;
            end
            steps++;
        end
        a.root = mid[31:0];
        a.status = going ? bqr_pkg::ST_CAP : bqr_pkg::ST_CONVERGED;
        a.steps = steps[7:0];
        return a;
    endfunction

    // input side: accept beat, predict
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            t_bracket b;
            b.left = i_left_bracket;
            b.right = i_right_bracket;
            answers_due.push_back(solve_bracket(b));
            void'(brackets_pending.pop_front());
            beat_taken <= 1;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !beat_taken)) begin
            beat_taken <= 0;
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 0;
            end else if (!hold && brackets_pending.size() > 0) begin
                i_left_bracket <= brackets_pending[0].left;
                i_right_bracket <= brackets_pending[0].right;
                i_valid <= 1;
                in_gap <= pick_gap();
            end else begin
                i_valid <= 0;
            end
        end
    end

    // result side stall
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
            out_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("result beat with nothing expected: root %h", o_root);
                fails++;
            end else begin
                t_answer e;
                e = answers_due.pop_front();
                if (o_root !== e.root) begin
                    $error("root: expected %h actual %h", e.root, o_root);
                    fails++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    fails++;
                end
                if (o_steps_taken !== e.steps) begin
                    $error("steps_taken: expected %0d actual %0d", e.steps, o_steps_taken);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("bisection_quartic_root regression: fail");
            $finish;
        end
    end

    task automatic write_reg(bqr_pkg::t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            bqr_pkg::REG_COEF_X4: m_c4 = val;
            bqr_pkg::REG_COEF_X3: m_c3 = val;
            bqr_pkg::REG_COEF_X2: m_c2 = val;
            bqr_pkg::REG_COEF_X1: m_c1 = val;
            bqr_pkg::REG_COEF_X0: m_c0 = val;
            bqr_pkg::REG_TOL: m_tol = val[15:0];
            bqr_pkg::REG_MAXIT: m_maxit = val[7:0];
            default: ;
        endcase
    endtask

    task automatic add_bracket(int l, int r);
        t_bracket b;
        b.left = l;
        b.right = r;
        brackets_pending.push_back(b);
    endtask

    function automatic int small_coef();
        return int'($urandom_range(0, 200 << FB)) - (100 << FB);
    endfunction

    task automatic wait_idle();
        wait (brackets_pending.size() == 0 && answers_due.size() == 0);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    initial begin
        int kind, l, r;
        m_c4 = 19 << FB;
        m_c3 = -(110 << FB);
        m_c2 = -(3300 << FB);
        m_c1 = 0;
        m_c0 = 12000 << FB;
        m_tol = 66;
        m_maxit = 64;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;

        // directed, reset coefficients
        add_bracket(0, 0);
        add_bracket(32'h8000_0000, 32'h7FFF_FFFF);
        add_bracket(32'h7FFF_FFFF, 32'h8000_0000);
        add_bracket(-1, 1);
        add_bracket(0, 10 << FB);
        add_bracket(-(10 << FB), 0);
        add_bracket(1 << FB, 20 << FB);
        add_bracket(20 << FB, 1 << FB);
        add_bracket(5 << FB, 5 << FB);
        add_bracket(-(20 << FB), -(1 << FB));
        add_bracket(10 << FB, 30 << FB);
        add_bracket(-(30 << FB), -(5 << FB));
        add_bracket(2 << FB, 3 << FB);
        add_bracket(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_bracket(32'h8000_0000, 32'h8000_0000);
        add_bracket(-(100 << FB), 100 << FB);
        // sender pauses until all results are back
        wait (brackets_pending.size() <= 8);
        hold = 1;
        wait (answers_due.size() == 0 && !i_valid);
        hold = 0;

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            case (ph)
                0: ;
                1: begin
                    write_reg(bqr_pkg::REG_COEF_X4, small_coef());
                    write_reg(bqr_pkg::REG_COEF_X3, small_coef());
                    write_reg(bqr_pkg::REG_COEF_X2, small_coef());
                    write_reg(bqr_pkg::REG_COEF_X1, small_coef());
                    write_reg(bqr_pkg::REG_COEF_X0, small_coef());
                    write_reg(bqr_pkg::REG_TOL, 66);
                    write_reg(bqr_pkg::REG_MAXIT, 64);
                end
                2: begin
                    write_reg(bqr_pkg::REG_COEF_X4, 32'h7FFF_FFFF);
                    write_reg(bqr_pkg::REG_COEF_X3, 32'h7FFF_FFFF);
                    write_reg(bqr_pkg::REG_COEF_X2, 32'h8000_0000);
                    write_reg(bqr_pkg::REG_COEF_X1, 32'h7FFF_FFFF);
                    write_reg(bqr_pkg::REG_COEF_X0, 32'h8000_0000);
                    write_reg(bqr_pkg::REG_TOL, 16'hFFFF);
                    write_reg(bqr_pkg::REG_MAXIT, 1);
                end
                3: begin
                    write_reg(bqr_pkg::REG_COEF_X4, 32'h8000_0000);
                    write_reg(bqr_pkg::REG_COEF_X3, 32'h8000_0000);
                    write_reg(bqr_pkg::REG_COEF_X2, 32'h7FFF_FFFF);
                    write_reg(bqr_pkg::REG_COEF_X1, 32'h8000_0000);
                    write_reg(bqr_pkg::REG_COEF_X0, 32'h7FFF_FFFF);
                    write_reg(bqr_pkg::REG_TOL, 0);
                    write_reg(bqr_pkg::REG_MAXIT, 255);
                end
                4: begin
                    write_reg(bqr_pkg::REG_COEF_X4, 19 << FB);
                    write_reg(bqr_pkg::REG_COEF_X3, -(110 << FB));
                    write_reg(bqr_pkg::REG_COEF_X2, -(3300 << FB));
                    write_reg(bqr_pkg::REG_COEF_X1, 0);
                    write_reg(bqr_pkg::REG_COEF_X0, 12000 << FB);
                    write_reg(bqr_pkg::REG_TOL, 0);
                    write_reg(bqr_pkg::REG_MAXIT, 255);
                end
                5: begin
                    write_reg(bqr_pkg::REG_TOL, 16'hFFFF);
                    write_reg(bqr_pkg::REG_MAXIT, 1);
                end
                default: begin
                    write_reg(bqr_pkg::REG_COEF_X4, (ph % 2) ? small_coef() : $urandom());
                    write_reg(bqr_pkg::REG_COEF_X3, (ph % 2) ? small_coef() : $urandom());
                    write_reg(bqr_pkg::REG_COEF_X2, $urandom());
                    write_reg(bqr_pkg::REG_COEF_X1, $urandom());
                    write_reg(bqr_pkg::REG_COEF_X0, $urandom());
                    write_reg(bqr_pkg::REG_TOL, $urandom_range(0, 16'hFFFF));
                    write_reg(bqr_pkg::REG_MAXIT, $urandom_range(1, 80));
                end
            endcase
            @(negedge i_clk);
            i_cfg_we <= 0;
            for (int n = 0; n < 95; n++) begin
                kind = $urandom_range(0, 9);
                if (kind < 2) begin
                    l = $urandom();
                    r = $urandom();
                end else if (kind < 8) begin
                    l = int'($urandom_range(0, 200 << FB)) - (100 << FB);
                    r = l + int'($urandom_range(1, 120 << FB));
                end else if (kind == 8) begin
                    r = int'($urandom_range(0, 200 << FB)) - (100 << FB);
                    l = r + int'($urandom_range(0, 50 << FB));
                end else begin
                    l = $urandom_range(0, 100 << FB);
                    r = ($urandom_range(0, 1)) ? -l : l;
                    l = -l;
                end
                add_bracket(l, r);
            end
        end

        wait (brackets_pending.size() == 0 && answers_due.size() == 0);
        repeat (DRAIN) @(negedge i_clk);
        if (fails == 0 && answers_due.size() == 0) begin
            $display("bisection_quartic_root regression: pass");
        end else begin
            $display("bisection_quartic_root regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
